>>> hdl/resol_pkg.sv
// Shared types for the ring entry store with byte-offset lookup.
// Used by resol_cell and ring_entry_store_offset_lookup_unit; depends on nothing.
package resol_pkg;

    // Fixed field widths of the request and result items.
    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned LENGTH_W = 16;
    localparam int unsigned BYTEPOS_W = 20;
    localparam int unsigned SLOT_W = 6;

    // Request codes.
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    // One stored entry, tagged with the ring slot that it occupies.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
        logic [SLOT_W-1:0]   slot;
    } entry_t;

    // A lookup in flight along the chain: remaining offset and, once hit, the answer.
    typedef struct packed {
        logic                 hit;
        logic [BYTEPOS_W-1:0] pos;
        logic [SLOT_W-1:0]    slot;
        logic [HANDLE_W-1:0]  handle;
        logic [LENGTH_W-1:0]  length;
        logic [LENGTH_W-1:0]  offset;
    } query_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic ent_load;
        logic ent_valid;
        logic q_adv;
    } cell_ctrl_t;

endpackage

>>> hdl/resol_cell.sv
// One cell of the entry chain: holds one entry and tests a passing lookup against it.
// Depends on resol_pkg.
module resol_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  resol_pkg::cell_ctrl_t ctrl,
    input  resol_pkg::entry_t   ent_in,
    output resol_pkg::entry_t   ent_out,
    input  logic                q_in_valid,
    input  resol_pkg::query_t   q_in,
    output logic                q_out_valid,
    output resol_pkg::query_t   q_out
);

    resol_pkg::entry_t ent_reg;
    resol_pkg::query_t q_reg;
    resol_pkg::query_t q_next;
    logic              q_valid_reg;

    // Entry storage: loaded on an add, or from the neighbour when the ring shifts.
    always_ff @(posedge aclk) begin
        if (ctrl.ent_load) begin
            ent_reg <= ent_in;
        end
    end

    // Test the lookup against this entry; a miss consumes the entry's bytes.
    always_comb begin
        q_next = q_in;
        if (!q_in.hit && ctrl.ent_valid) begin
            if (q_in.pos < resol_pkg::BYTEPOS_W'(ent_reg.length)) begin
                q_next.hit    = 1'b1;
                q_next.slot   = ent_reg.slot;
                q_next.handle = ent_reg.handle;
                q_next.length = ent_reg.length;
                q_next.offset = q_in.pos[resol_pkg::LENGTH_W-1:0];
            end else begin
                q_next.pos = q_in.pos - resol_pkg::BYTEPOS_W'(ent_reg.length);
            end
        end
    end

    // Hand the lookup on to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (ctrl.q_adv) begin
            q_valid_reg <= q_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.q_adv) begin
            q_reg <= q_next;
        end
    end

    assign ent_out     = ent_reg;
    assign q_out_valid = q_valid_reg;
    assign q_out       = q_reg;

endmodule

>>> hdl/ring_entry_store_offset_lookup_unit.sv
// Top level of the ring entry store with byte-offset lookup.
// Depends on resol_pkg and resol_cell.
//
// A ring of RING_DEPTH entries, each a 32-bit handle and a 16-bit byte length, is
// kept in a chain of cells ordered oldest first. An add returns nothing; when the
// ring is full the chain shifts by one, dropping the oldest entry. A find passes
// through the launch register and travels down the chain one cell per cycle to the
// output register, and no new request is taken until the lookup has left the chain.
// A waiting result does not block the next request, but a finished lookup holds at
// the end of the chain until the output register is free. Zero-length entries are
// passed over; an offset at or past the stored total returns a result with every
// field zero.
module ring_entry_store_offset_lookup_unit #(
    parameter int unsigned RING_DEPTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_entry_handle,
    input  logic [15:0] s_entry_length,
    input  logic [19:0] s_byte_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [5:0]  m_slot,
    output logic [31:0] m_hit_handle,
    output logic [15:0] m_hit_length,
    output logic [15:0] m_byte_in_entry
);

    localparam int unsigned POS_W = $clog2(RING_DEPTH);
    localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

    logic [POS_W-1:0] write_pos_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ring_full;
    logic             add_xfer;
    logic             find_xfer;
    logic             busy;
    logic             adv;

    resol_pkg::entry_t     new_entry;
    resol_pkg::entry_t     ent_in   [RING_DEPTH];
    resol_pkg::entry_t     ent_out  [RING_DEPTH];
    resol_pkg::cell_ctrl_t ctrl     [RING_DEPTH];
    resol_pkg::query_t     q_stage  [RING_DEPTH+1];
    logic [RING_DEPTH:0]   q_valid;

    logic              launch_valid_reg;
    resol_pkg::query_t launch_reg;
    resol_pkg::query_t launch_next;

    logic              m_valid_reg;
    resol_pkg::query_t m_reg;

    // Request handshake: the chain takes one lookup at a time.
    assign busy      = |q_valid;
    assign s_ready   = !busy;
    assign add_xfer  = s_valid && s_ready && (s_req_type == resol_pkg::REQ_ADD);
    assign find_xfer = s_valid && s_ready && (s_req_type == resol_pkg::REQ_FIND);
    assign ring_full = (count_reg == CNT_W'(RING_DEPTH));

    // The chain advances unless a finished lookup faces a stalled output register.
    assign adv = !(q_valid[RING_DEPTH] && m_valid_reg && !m_ready);

    // Write position and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pos_reg <= '0;
            count_reg     <= '0;
        end else if (add_xfer) begin
            if (write_pos_reg == POS_W'(RING_DEPTH - 1)) begin
                write_pos_reg <= '0;
            end else begin
                write_pos_reg <= write_pos_reg + POS_W'(1);
            end
            if (!ring_full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    assign new_entry.handle = s_entry_handle;
    assign new_entry.length = s_entry_length;
    assign new_entry.slot   = resol_pkg::SLOT_W'(write_pos_reg);

    // Launch stage: a find enters the chain with its full offset and no hit yet.
    always_comb begin
        launch_next     = '0;
        launch_next.pos = s_byte_position;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_valid_reg <= 1'b0;
        end else if (find_xfer) begin
            launch_valid_reg <= 1'b1;
        end else if (adv) begin
            launch_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (find_xfer) begin
            launch_reg <= launch_next;
        end
    end

    assign q_valid[0] = launch_valid_reg;
    assign q_stage[0] = launch_reg;

    // The chain of cells: entries shift towards cell 0 when a full ring is added to.
    for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
        if (k == RING_DEPTH - 1) begin : g_last
            assign ent_in[k] = new_entry;
        end else begin : g_mid
            assign ent_in[k] = ring_full ? ent_out[k+1] : new_entry;
        end

        assign ctrl[k].ent_load  = add_xfer && (ring_full || (count_reg == CNT_W'(k)));
        assign ctrl[k].ent_valid = (count_reg > CNT_W'(k));
        assign ctrl[k].q_adv     = adv;

        resol_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl[k]),
            .ent_in      (ent_in[k]),
            .ent_out     (ent_out[k]),
            .q_in_valid  (q_valid[k]),
            .q_in        (q_stage[k]),
            .q_out_valid (q_valid[k+1]),
            .q_out       (q_stage[k+1])
        );
    end

    // Output register: takes the lookup leaving the last cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && q_valid[RING_DEPTH]) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && q_valid[RING_DEPTH]) begin
            m_reg <= q_stage[RING_DEPTH];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_reg.hit;
    assign m_slot          = m_reg.slot;
    assign m_hit_handle    = m_reg.handle;
    assign m_hit_length    = m_reg.length;
    assign m_byte_in_entry = m_reg.offset;

endmodule
